### rtl/tpr_pkg.sv
package tpr_pkg;

    localparam int PACKET_BYTES     = 188;
    localparam int PES_HEADER_BYTES = 6;
    localparam int COUNT_BITS       = 24;
    localparam int PID_BITS         = 13;
    localparam int LEN_BITS         = 17;
    localparam int POS_BITS         = 8;
    localparam int HOLD_IDX_BITS    = $clog2(PES_HEADER_BYTES);
    localparam int CMD_DEPTH        = 8;
    localparam int CMD_PTR_BITS     = $clog2(CMD_DEPTH);

    localparam logic [3:0]            CC_MASK   = 4'hF;
    localparam logic [PID_BITS-1:0]   PID_RESET = {PID_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // status codes on the result port
    localparam logic [2:0] ST_OTHER    = 3'd0;
    localparam logic [2:0] ST_LOST     = 3'd1;
    localparam logic [2:0] ST_STARTED  = 3'd2;
    localparam logic [2:0] ST_CONTINUE = 3'd3;
    localparam logic [2:0] ST_FINISHED = 3'd4;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // per-packet verdict
    typedef enum logic [2:0] {
        V_OTHER    = 3'd0,
        V_LOST     = 3'd1,
        V_START    = 3'd2,
        V_CONT     = 3'd3,
        V_FINISHED = 3'd4,
        V_DATA     = 3'd5,
        V_WAIT_AF  = 3'd6
    } verdict_t;

    // how many data results a command carries
    typedef enum logic [1:0] {
        SEL_NONE = 2'd0,
        SEL_ONE  = 2'd1,
        SEL_SIX  = 2'd2
    } data_sel_t;

    typedef struct packed {
        logic [7:0] ts_byte;
        logic       packet_start;
    } in_item_t;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            data_byte;
        logic [2:0]            status;
        logic [COUNT_BITS-1:0] assembled_count;
        logic [LEN_BITS-1:0]   expected_length;
        logic                  last;
    } out_item_t;

    // work handed from the parser to the result generator
    typedef struct packed {
        data_sel_t                              data_sel;
        logic                                   has_status;
        logic [2:0]                             status;
        logic [PES_HEADER_BYTES-1:0][7:0]       bytes;
        logic [COUNT_BITS-1:0]                  count_base;
        logic [LEN_BITS-1:0]                    full_length;
    } cmd_t;

    function automatic logic [COUNT_BITS-1:0] count_sat_add(
        input logic [COUNT_BITS-1:0] base,
        input logic [2:0]            inc
    );
        logic [COUNT_BITS:0] sum;
        sum = {1'b0, base} + {{(COUNT_BITS-2){1'b0}}, inc};
        return sum[COUNT_BITS] ? COUNT_MAX : sum[COUNT_BITS-1:0];
    endfunction

endpackage

### rtl/ts_pes_reassembler.sv
// Transport stream PES reassembler. Takes one transport packet byte per cycle
// while full is low and returns PES payload bytes of the configured PID plus
// one status item on the last byte of every packet. The parser accepts a byte
// each such cycle and writes at most one work entry per byte into an 8-entry
// command queue; the result stage drains it one result item per cycle while
// pop is high, through a registered output. Most bytes cause zero or one item,
// so the sustained rate is one byte per cycle while pop stays high; the byte
// that completes a PES header yields six data items (seven on the last byte of
// a packet), which the queue absorbs while the following header bytes of the
// next packet yield nothing. full rises only when the command queue holds 8
// entries. A byte's first result goes via the queue, then the output register.
// pid is written through cfg_wr_en/cfg_wr_data and must only change while the
// block is idle; it resets to 8191. No sync byte check is made: packet_start
// high restarts framing at byte 0, otherwise a packet is 188 bytes.
module ts_pes_reassembler (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [tpr_pkg::PID_BITS-1:0] cfg_wr_data,
    input  logic                         push,
    output logic                         full,
    input  tpr_pkg::in_item_t            ts_item,
    output logic                         empty,
    input  logic                         pop,
    output tpr_pkg::out_item_t           result
);

    logic          accept;
    logic          cmd_push;
    tpr_pkg::cmd_t cmd_in;
    tpr_pkg::cmd_t cmd_out;
    logic          cmd_pop;
    logic          cmd_empty;

    // an item enters when the command queue has room
    assign accept = push && !full;

    tpr_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item        (ts_item),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in)
    );

    tpr_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_out),
        .full    (full),
        .empty   (cmd_empty)
    );

    // expands each queued command into data and status items
    tpr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .pop       (pop),
        .empty     (empty),
        .result    (result)
    );

endmodule

### rtl/tpr_front.sv
module tpr_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [tpr_pkg::PID_BITS-1:0]   cfg_wr_data,
    input  logic                           accept,
    input  tpr_pkg::in_item_t              item,
    output logic                           cmd_push,
    output tpr_pkg::cmd_t                  cmd
);

    localparam logic [tpr_pkg::POS_BITS-1:0] LAST_POS =
        tpr_pkg::POS_BITS'(tpr_pkg::PACKET_BYTES - 1);
    localparam logic [tpr_pkg::POS_BITS-1:0] OFF_LIMIT =
        tpr_pkg::POS_BITS'(tpr_pkg::PACKET_BYTES - tpr_pkg::PES_HEADER_BYTES);
    localparam logic [tpr_pkg::POS_BITS-1:0] HDR_OFF = tpr_pkg::POS_BITS'(4);
    localparam logic [tpr_pkg::POS_BITS-1:0] HOLD_N =
        tpr_pkg::POS_BITS'(tpr_pkg::PES_HEADER_BYTES);
    localparam logic [tpr_pkg::POS_BITS-1:0] HOLD_LAST =
        tpr_pkg::POS_BITS'(tpr_pkg::PES_HEADER_BYTES - 1);

    logic [tpr_pkg::PID_BITS-1:0]   pid_reg;
    logic [tpr_pkg::POS_BITS-1:0]   pos_reg, pos_next;
    logic [23:0]                    hdr_reg, hdr_next;
    logic [tpr_pkg::POS_BITS-1:0]   off_reg, off_next;
    tpr_pkg::verdict_t              verdict_reg, verdict_next;
    logic [3:0]                     prev_cc_reg, prev_cc_next;
    logic                           prev_ok_reg, prev_ok_next;
    logic                           asm_reg, asm_next;
    logic [tpr_pkg::LEN_BITS-1:0]   flen_reg, flen_next;
    logic [tpr_pkg::COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic [7:0]                     hold_reg [tpr_pkg::PES_HEADER_BYTES];

    logic [tpr_pkg::POS_BITS-1:0]   pos_v;
    logic [tpr_pkg::POS_BITS-1:0]   idx;
    logic [8:0]                     af_off;
    logic [tpr_pkg::PID_BITS-1:0]   hdr_pid;
    logic [3:0]                     cc;
    logic [15:0]                    pes_len;
    logic                           do_open;
    logic                           fin;
    logic                           hold_we;
    logic [7:0]                     b;

    assign b = item.ts_byte;

    always_comb
    begin
        pos_v        = item.packet_start ? '0 : pos_reg;
        hdr_next     = hdr_reg;
        off_next     = off_reg;
        verdict_next = verdict_reg;
        prev_cc_next = prev_cc_reg;
        prev_ok_next = prev_ok_reg;
        asm_next     = asm_reg;
        flen_next    = flen_reg;
        cnt_next     = cnt_reg;
        do_open      = 1'b0;
        hold_we      = 1'b0;
        fin          = 1'b0;
        idx          = pos_v - off_reg;
        af_off       = 9'd5 + {1'b0, b};
        hdr_pid      = '0;
        cc           = '0;
        pes_len      = {hold_reg[4], b};
        cmd          = '0;
        cmd.data_sel = tpr_pkg::SEL_NONE;

        if (pos_v == '0)
        begin
            verdict_next = tpr_pkg::V_OTHER;
            off_next     = HDR_OFF;
            hdr_next     = '0;
        end
        else if (pos_v <= tpr_pkg::POS_BITS'(3))
        begin
            case (pos_v[1:0])
                2'd1:    hdr_next[23:16] = b;
                2'd2:    hdr_next[15:8]  = b;
                default: hdr_next[7:0]   = b;
            endcase
            if (pos_v[1:0] == 2'd3)
            begin
                hdr_pid = {hdr_next[20:16], hdr_next[15:8]};
                cc      = hdr_next[3:0] & tpr_pkg::CC_MASK;
                if (hdr_pid != pid_reg)
                    verdict_next = tpr_pkg::V_OTHER;
                else if (!hdr_next[4])
                    verdict_next = tpr_pkg::V_CONT;
                else if (prev_ok_reg && cc == prev_cc_reg)
                    verdict_next = tpr_pkg::V_CONT;
                else if (prev_ok_reg && cc != ((prev_cc_reg + 4'd1) & tpr_pkg::CC_MASK))
                begin
                    asm_next     = 1'b0;
                    cnt_next     = '0;
                    flen_next    = '0;
                    prev_cc_next = cc;
                    verdict_next = tpr_pkg::V_LOST;
                end
                else
                begin
                    prev_cc_next = cc;
                    prev_ok_next = 1'b1;
                    if (hdr_next[5])
                        verdict_next = tpr_pkg::V_WAIT_AF;
                    else
                    begin
                        off_next = HDR_OFF;
                        do_open  = 1'b1;
                    end
                end
            end
        end
        else if (pos_v == HDR_OFF && verdict_reg == tpr_pkg::V_WAIT_AF)
        begin
            if (af_off >= 9'(tpr_pkg::PACKET_BYTES))
                verdict_next = tpr_pkg::V_LOST;
            else
            begin
                off_next = af_off[tpr_pkg::POS_BITS-1:0];
                do_open  = 1'b1;
            end
        end
        else if (pos_v >= off_reg &&
                 (verdict_reg == tpr_pkg::V_START || verdict_reg == tpr_pkg::V_DATA))
        begin
            if (verdict_reg == tpr_pkg::V_START && idx < HOLD_N)
            begin
                hold_we = 1'b1;
                if (idx == HOLD_LAST)
                begin
                    if (hold_reg[0] != 8'h00 || hold_reg[1] != 8'h00 || hold_reg[2] != 8'h01)
                    begin
                        asm_next     = 1'b0;
                        verdict_next = tpr_pkg::V_LOST;
                    end
                    else
                    begin
                        flen_next = (pes_len == '0) ? '0 :
                            {1'b0, pes_len} + tpr_pkg::LEN_BITS'(tpr_pkg::PES_HEADER_BYTES);
                        cmd.data_sel   = tpr_pkg::SEL_SIX;
                        cmd.bytes[0]   = hold_reg[0];
                        cmd.bytes[1]   = hold_reg[1];
                        cmd.bytes[2]   = hold_reg[2];
                        cmd.bytes[3]   = hold_reg[3];
                        cmd.bytes[4]   = hold_reg[4];
                        cmd.bytes[5]   = b;
                        cmd.count_base = cnt_reg;
                        cnt_next = tpr_pkg::count_sat_add(cnt_reg,
                            3'(tpr_pkg::PES_HEADER_BYTES));
                    end
                end
            end
            else if (flen_reg == '0 ||
                     cnt_reg < {{(tpr_pkg::COUNT_BITS-tpr_pkg::LEN_BITS){1'b0}}, flen_reg})
            begin
                cmd.data_sel   = tpr_pkg::SEL_ONE;
                cmd.bytes[0]   = b;
                cmd.count_base = cnt_reg;
                cnt_next       = tpr_pkg::count_sat_add(cnt_reg, 3'd1);
            end
        end

        // payload opening: a start packet resets assembly
        if (do_open)
        begin
            if (hdr_next[22])
            begin
                cnt_next  = '0;
                flen_next = '0;
                if (off_next > OFF_LIMIT)
                begin
                    asm_next     = 1'b0;
                    verdict_next = tpr_pkg::V_LOST;
                end
                else
                begin
                    asm_next     = 1'b1;
                    verdict_next = tpr_pkg::V_START;
                end
            end
            else if (!asm_reg)
                verdict_next = tpr_pkg::V_LOST;
            else if (flen_reg != '0 &&
                     cnt_reg >= {{(tpr_pkg::COUNT_BITS-tpr_pkg::LEN_BITS){1'b0}}, flen_reg})
            begin
                asm_next     = 1'b0;
                verdict_next = tpr_pkg::V_FINISHED;
            end
            else
                verdict_next = tpr_pkg::V_DATA;
        end

        // end of packet status
        if (pos_v == LAST_POS)
        begin
            fin = flen_next != '0 &&
                  cnt_next >= {{(tpr_pkg::COUNT_BITS-tpr_pkg::LEN_BITS){1'b0}}, flen_next};
            cmd.has_status = 1'b1;
            if (cmd.data_sel == tpr_pkg::SEL_NONE)
                cmd.count_base = cnt_next;
            unique case (verdict_next) inside
                tpr_pkg::V_OTHER:    cmd.status = tpr_pkg::ST_OTHER;
                tpr_pkg::V_FINISHED: cmd.status = tpr_pkg::ST_FINISHED;
                tpr_pkg::V_CONT:     cmd.status = tpr_pkg::ST_CONTINUE;
                tpr_pkg::V_START:
                begin
                    cmd.status = fin ? tpr_pkg::ST_FINISHED : tpr_pkg::ST_STARTED;
                    if (fin)
                        asm_next = 1'b0;
                end
                tpr_pkg::V_DATA:
                begin
                    cmd.status = fin ? tpr_pkg::ST_FINISHED : tpr_pkg::ST_CONTINUE;
                    if (fin)
                        asm_next = 1'b0;
                end
                tpr_pkg::V_LOST, tpr_pkg::V_WAIT_AF: cmd.status = tpr_pkg::ST_LOST;
                default:             cmd.status = tpr_pkg::ST_LOST;
            endcase
        end

        cmd.full_length = flen_next;
        pos_next        = (pos_v == LAST_POS) ? '0 : pos_v + 1'b1;
        cmd_push        = accept && (cmd.has_status || cmd.data_sel != tpr_pkg::SEL_NONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pid_reg     <= tpr_pkg::PID_RESET;
            pos_reg     <= '0;
            hdr_reg     <= '0;
            off_reg     <= HDR_OFF;
            verdict_reg <= tpr_pkg::V_OTHER;
            prev_cc_reg <= '0;
            prev_ok_reg <= 1'b0;
            asm_reg     <= 1'b0;
            flen_reg    <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                pid_reg <= cfg_wr_data;
            if (accept)
            begin
                pos_reg     <= pos_next;
                hdr_reg     <= hdr_next;
                off_reg     <= off_next;
                verdict_reg <= verdict_next;
                prev_cc_reg <= prev_cc_next;
                prev_ok_reg <= prev_ok_next;
                asm_reg     <= asm_next;
                flen_reg    <= flen_next;
                cnt_reg     <= cnt_next;
            end
        end
    end

    // PES header bytes, written before read within one packet
    always_ff @(posedge clk)
    begin
        if (accept && hold_we)
            hold_reg[idx[tpr_pkg::HOLD_IDX_BITS-1:0]] <= b;
    end

endmodule

### rtl/tpr_cmd_fifo.sv
module tpr_cmd_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tpr_pkg::cmd_t wr_data,
    input  logic          rd_en,
    output tpr_pkg::cmd_t rd_data,
    output logic          full,
    output logic          empty
);

    tpr_pkg::cmd_t                    mem_reg [tpr_pkg::CMD_DEPTH];
    logic [tpr_pkg::CMD_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [tpr_pkg::CMD_PTR_BITS:0]   cnt_reg, cnt_next;

    assign full    = cnt_reg == (tpr_pkg::CMD_PTR_BITS+1)'(tpr_pkg::CMD_DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !(rd_en && !empty))
            cnt_next = cnt_reg + 1'b1;
        else if (!wr_en && rd_en && !empty)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr_en)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (rd_en && !empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

### rtl/tpr_back.sv
module tpr_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    input  tpr_pkg::cmd_t      cmd,
    output logic               cmd_pop,
    input  logic               pop,
    output logic               empty,
    output tpr_pkg::out_item_t result
);

    logic [2:0]         step_reg, step_next;
    logic               out_valid_reg, out_valid_next;
    tpr_pkg::out_item_t out_reg, out_next;
    logic [2:0]         n_data;
    logic               at_end;
    logic               load;

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    always_comb
    begin
        case (cmd.data_sel)
            tpr_pkg::SEL_ONE: n_data = 3'd1;
            tpr_pkg::SEL_SIX: n_data = 3'(tpr_pkg::PES_HEADER_BYTES);
            default:          n_data = 3'd0;
        endcase
        at_end = cmd.has_status ? (step_reg == n_data) : (step_reg == n_data - 3'd1);
        load   = !out_valid_reg || pop;

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        step_next      = step_reg;
        cmd_pop        = 1'b0;

        if (load)
        begin
            out_valid_next = cmd_valid;
            if (cmd_valid)
            begin
                out_next.expected_length = cmd.full_length;
                if (step_reg < n_data)
                begin
                    out_next.kind            = tpr_pkg::KIND_DATA;
                    out_next.data_byte       = cmd.bytes[step_reg];
                    out_next.status          = tpr_pkg::ST_OTHER;
                    out_next.assembled_count =
                        tpr_pkg::count_sat_add(cmd.count_base, step_reg + 3'd1);
                    out_next.last            = at_end;
                end
                else
                begin
                    out_next.kind            = tpr_pkg::KIND_STATUS;
                    out_next.data_byte       = '0;
                    out_next.status          = cmd.status;
                    out_next.assembled_count =
                        tpr_pkg::count_sat_add(cmd.count_base, n_data);
                    out_next.last            = 1'b1;
                end
                cmd_pop   = at_end;
                step_next = at_end ? '0 : step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

### sim/tb.sv
import tpr_pkg::*;

// Mirrors the parser state and keeps the result items still owed by the block.
class pes_scoreboard;
    out_item_t   expected_q[$];
    int          errors;

    logic [PID_BITS-1:0] pid;
    int          pos;
    logic [23:0] hdr;
    int          pay_off;
    verdict_t    verdict;
    logic [3:0]  last_cc;
    bit          last_cc_ok;
    bit          assembling;
    logic [7:0]  hold [PES_HEADER_BYTES];
    int unsigned full_len;
    int unsigned count;

    function new();
        errors     = 0;
        pid        = PID_RESET;
        pos        = 0;
        hdr        = '0;
        pay_off    = 4;
        verdict    = V_OTHER;
        last_cc    = '0;
        last_cc_ok = 0;
        assembling = 0;
        full_len   = 0;
        count      = 0;
    endfunction

    function void bump_count();
        if (count < COUNT_MAX)
            count++;
    endfunction

    function void emit(logic k, logic [7:0] d, logic [2:0] s);
        out_item_t r;
        r.kind            = k;
        r.data_byte       = d;
        r.status          = s;
        r.assembled_count = COUNT_BITS'(count);
        r.expected_length = LEN_BITS'(full_len);
        r.last            = 1'b0;
        expected_q.push_back(r);
    endfunction

    // payload about to begin: decide how this packet feeds the PES
    function void start_payload();
        if (hdr[22])
        begin
            count      = 0;
            full_len   = 0;
            assembling = 1;
            if (PACKET_BYTES - pay_off < PES_HEADER_BYTES)
            begin
                assembling = 0;
                verdict    = V_LOST;
            end
            else
                verdict = V_START;
        end
        else if (!assembling)
            verdict = V_LOST;
        else if (full_len != 0 && count >= full_len)
        begin
            assembling = 0;
            verdict    = V_FINISHED;
        end
        else
            verdict = V_DATA;
    endfunction

    // header complete: PID match, payload flag, continuity
    function void classify_header();
        logic [PID_BITS-1:0] id;
        logic [3:0]          cc;
        id = {hdr[20:16], hdr[15:8]};
        cc = hdr[3:0] & CC_MASK;
        if (id != pid)
        begin
            verdict = V_OTHER;
            return;
        end
        if (!hdr[4])
        begin
            verdict = V_CONT;
            return;
        end
        if (last_cc_ok)
        begin
            if (cc == last_cc)
            begin
                verdict = V_CONT;
                return;
            end
            if (cc != ((last_cc + 4'd1) & CC_MASK))
            begin
                assembling = 0;
                count      = 0;
                full_len   = 0;
                last_cc    = cc;
                verdict    = V_LOST;
                return;
            end
        end
        last_cc    = cc;
        last_cc_ok = 1;
        if (hdr[5])
            verdict = V_WAIT_AF;
        else
        begin
            pay_off = 4;
            start_payload();
        end
    endfunction

    // one accepted byte: advance the mirror, queue the result items it causes
    function void note_byte(in_item_t it);
        int          p;
        int          idx;
        int          base;
        int unsigned plen;
        bit          fin;
        logic [2:0]  st;
        out_item_t   r;
        base = expected_q.size();
        if (it.packet_start)
            pos = 0;
        p = pos;
        if (p == 0)
        begin
            verdict = V_OTHER;
            pay_off = 4;
            hdr     = '0;
        end
        else if (p <= 3)
        begin
            hdr |= 24'(it.ts_byte) << (8 * (3 - p));
            if (p == 3)
                classify_header();
        end
        else if (p == 4 && verdict == V_WAIT_AF)
        begin
            if (5 + int'(it.ts_byte) >= PACKET_BYTES)
                verdict = V_LOST;
            else
            begin
                pay_off = 5 + int'(it.ts_byte);
                start_payload();
            end
        end
        else if (p >= pay_off && (verdict == V_START || verdict == V_DATA))
        begin
            idx = p - pay_off;
            if (verdict == V_START && idx < PES_HEADER_BYTES)
            begin
                hold[idx] = it.ts_byte;
                if (idx == PES_HEADER_BYTES - 1)
                begin
                    if (hold[0] != 8'h00 || hold[1] != 8'h00 || hold[2] != 8'h01)
                    begin
                        assembling = 0;
                        verdict    = V_LOST;
                    end
                    else
                    begin
                        plen     = {hold[4], hold[5]};
                        full_len = (plen == 0) ? 0 : plen + PES_HEADER_BYTES;
                        for (int i = 0; i < PES_HEADER_BYTES; i++)
                        begin
                            bump_count();
                            emit(KIND_DATA, hold[i], ST_OTHER);
                        end
                    end
                end
            end
            else if (full_len == 0 || count < full_len)
            begin
                bump_count();
                emit(KIND_DATA, it.ts_byte, ST_OTHER);
            end
        end
        if (p == PACKET_BYTES - 1)
        begin
            fin = (full_len != 0 && count >= full_len);
            case (verdict)
                V_OTHER:    st = ST_OTHER;
                V_FINISHED: st = ST_FINISHED;
                V_CONT:     st = ST_CONTINUE;
                V_START:
                begin
                    if (fin)
                    begin
                        assembling = 0;
                        st         = ST_FINISHED;
                    end
                    else
                        st = ST_STARTED;
                end
                V_DATA:
                begin
                    if (fin)
                    begin
                        assembling = 0;
                        st         = ST_FINISHED;
                    end
                    else
                        st = ST_CONTINUE;
                end
                default:    st = ST_LOST;
            endcase
            emit(KIND_STATUS, 8'h00, st);
        end
        if (expected_q.size() > base)
        begin
            r      = expected_q.pop_back();
            r.last = 1'b1;
            expected_q.push_back(r);
        end
        pos = p + 1;
        if (pos >= PACKET_BYTES)
            pos = 0;
    endfunction

    function void check_result(out_item_t got);
        out_item_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected result item: kind %0d byte %02h status %0d",
                         got.kind, got.data_byte, got.status);
            return;
        end
        want = expected_q.pop_front();
        if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
            got.status !== want.status || got.assembled_count !== want.assembled_count ||
            got.expected_length !== want.expected_length || got.last !== want.last)
        begin
            errors++;
            if (errors <= 10)
            begin
                $display("mismatch: want kind %0d byte %02h status %0d count %0d len %0d last %0d",
                         want.kind, want.data_byte, want.status, want.assembled_count,
                         want.expected_length, want.last);
                $display("          got  kind %0d byte %02h status %0d count %0d len %0d last %0d",
                         got.kind, got.data_byte, got.status, got.assembled_count,
                         got.expected_length, got.last);
            end
        end
    endfunction
endclass

module tb;

    localparam int CYCLE_LIMIT    = 2000000;
    localparam int SETTLE_CYCLES  = 16;   // parser plus command queue plus output reg

    typedef enum {RX_STEADY, RX_BURSTY, RX_COIN, RX_SLOW} rx_mode_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [PID_BITS-1:0] cfg_wr_data = '0;
    logic                push        = 1'b0;
    logic                full;
    in_item_t            ts_item     = '0;
    logic                empty;
    logic                pop         = 1'b0;
    out_item_t           result;

    pes_scoreboard       sb;

    // stimulus side state
    logic [7:0]          pkt [PACKET_BYTES];
    logic [PID_BITS-1:0] cur_pid     = PID_RESET;
    bit                  framing_broken = 0;
    int                  burst_left  = 0;

    // receiver side state
    rx_mode_t            rx_mode     = RX_STEADY;
    int                  mode_left   = 0;
    int                  stall_left  = 0;
    int unsigned         cycle_count = 0;

    ts_pes_reassembler u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .full        (full),
        .ts_item     (ts_item),
        .empty       (empty),
        .pop         (pop),
        .result      (result)
    );

    always #6 clk = ~clk;

    // Drive one byte; the sender runs in bursts with random gaps in between.
    // Acceptance is judged on full as sampled at the edge.
    task automatic send_byte(input logic [7:0] b, input logic ps);
        int       gap;
        in_item_t it;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                push <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            // now and then a long stretch with no idling
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(150, 600)
                                                     : $urandom_range(1, 24);
        end
        it.ts_byte      = b;
        it.packet_start = ps;
        push    <= 1'b1;
        ts_item <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_byte(it);
        burst_left--;
    endtask

    // Build one transport packet and send its first n bytes. A short send
    // leaves framing mid-packet, so the next packet must raise packet_start.
    task automatic send_ts_packet(input logic [PID_BITS-1:0] id, input bit pusi,
                                  input logic [1:0] afc, input logic [3:0] cc,
                                  input int af_len, input bit code_ok,
                                  input logic [15:0] pes_len, input int n);
        int   p;
        logic ps0;
        for (int i = 0; i < PACKET_BYTES; i++)
            pkt[i] = 8'($urandom);
        if ($urandom_range(0, 3) != 0)
            pkt[0] = 8'h47;        // sync is not checked, so it is random sometimes
        pkt[1] = {1'($urandom), pusi, 1'($urandom), id[12:8]};
        pkt[2] = id[7:0];
        pkt[3] = {2'($urandom), afc, cc};
        p = 4;
        if (afc[1])
        begin
            pkt[4] = 8'(af_len);
            p      = 5 + af_len;
        end
        // PES header: 00 00 01, stream id, length
        if (pusi && p + 5 < PACKET_BYTES)
        begin
            pkt[p]     = 8'h00;
            pkt[p + 1] = 8'h00;
            pkt[p + 2] = 8'h01;
            pkt[p + 4] = pes_len[15:8];
            pkt[p + 5] = pes_len[7:0];
            if (!code_ok)
                pkt[p + $urandom_range(0, 2)] ^= 8'(1 << $urandom_range(0, 7));
        end
        ps0 = framing_broken ? 1'b1 : 1'($urandom);
        for (int i = 0; i < n; i++)
            send_byte(pkt[i], (i == 0) ? ps0 : 1'b0);
        framing_broken = (n != PACKET_BYTES);
    endtask

    // One case per packet; counter starts fresh after reset. Most packets
    // are cut short so the whole run stays near 360 bytes; the last one is
    // full length and ends with six header bytes plus the status item.
    task automatic run_directed();
        logic [PID_BITS-1:0] p;
        p = cur_pid;
        send_ts_packet(p ^ 13'd1, 1, 2'b01, 4'd0, 0, 1, 16'd0, 16);         // other pid
        send_ts_packet(p, 1, 2'b01, 4'd0, 0, 1, 16'd0, 40);                 // unbounded start
        send_ts_packet(p, 0, 2'b01, 4'd1, 0, 1, 16'd0, 24);                 // continue
        send_ts_packet(p, 0, 2'b01, 4'd1, 0, 1, 16'd0, 16);                 // duplicate
        send_ts_packet(p, 0, 2'b01, 4'd5, 0, 1, 16'd0, 16);                 // counter gap
        send_ts_packet(p, 0, 2'b01, 4'd6, 0, 1, 16'd0, 16);                 // no start seen
        send_ts_packet(p, 1, 2'b01, 4'd7, 0, 0, 16'd0, 24);                 // bad start code
        send_ts_packet(p, 1, 2'b11, 4'd8, 255, 1, 16'd0, 20);               // adaptation too long
        send_ts_packet(p, 1, 2'b11, 4'd9, 177, 1, 16'd0, PACKET_BYTES);     // 7 items, last byte
    endtask

    // Wait until every owed item is out, then let byte-only work drain.
    task automatic settle();
        push <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_pid(input logic [PID_BITS-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.pid  = v;
        cur_pid = v;
    endtask

    // Receiver: checks each popped item and stalls in randomly changing modes,
    // from always ready to heavy back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
                sb.check_result(result);
            if (mode_left == 0)
            begin
                rx_mode   = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(32, 400);
            end
            else
                mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_STEADY: pop <= 1'b1;
                    RX_BURSTY:
                    begin
                        if ($urandom_range(0, 7) == 0)
                        begin
                            stall_left = $urandom_range(1, 8);
                            pop <= 1'b0;
                        end
                        else
                            pop <= 1'b1;
                    end
                    RX_COIN:   pop <= 1'($urandom);
                    default:   pop <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        write_pid(PID_BITS'($urandom_range(1, 8190)));
        run_directed();
        settle();
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
